### hdl/flat_histogram_monitor_defines.svh
// assertion macros shared by the histogram monitor modules
`ifndef FLAT_HISTOGRAM_MONITOR_DEFINES_SVH
`define FLAT_HISTOGRAM_MONITOR_DEFINES_SVH

// same-cycle implication
`define FHM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("histogram monitor check failed");

// next-cycle implication
`define FHM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("histogram monitor check failed");

`endif

### hdl/fhm_pkg.sv
package fhm_pkg;

  localparam int NUM_BINS   = 1024;
  localparam int COUNT_BITS = 32;

  localparam int ADDR_W   = $clog2(NUM_BINS);
  localparam int BIN_W    = 10;
  localparam int RANGE_W  = 11;
  localparam int CRIT_W   = 9;
  localparam int MINC_W   = 32;
  localparam int VBIN_W   = 11;
  localparam int SUMO_W   = 42;
  localparam int CNT_W    = $clog2(NUM_BINS + 1);
  localparam int SUM_W    = COUNT_BITS + CNT_W;
  localparam int MULY_W   = (CNT_W > CRIT_W) ? CNT_W : CRIT_W;
  localparam int PROD_W   = SUM_W + MULY_W;
  localparam int FLAT_SHIFT = 8;
  localparam int WORD_W   = COUNT_BITS + 1;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_BINS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_RANGE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLAT_CRIT   = 2'd2;

  localparam logic [RANGE_W-1:0] ACTIVE_BINS_RST = 11'd1024;
  localparam logic [RANGE_W-1:0] MIN_RANGE_RST   = 11'd1;
  localparam logic [CRIT_W-1:0]  FLAT_CRIT_RST   = 9'd204;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]     CLR_LAST  = ADDR_W'(NUM_BINS - 1);

  typedef enum logic [1:0] {
    OP_VISIT = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_SHORT = 2'd1,
    ERR_RANGE = 2'd2,
    ERR_BIN   = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_VWR,
    S_QRD,
    S_MUL1,
    S_MUL2,
    S_CMP,
    S_RESP
  } state_t;

  typedef struct packed {
    op_t                operation;
    logic [BIN_W-1:0]   bin_index;
    logic [RANGE_W-1:0] range_low;
    logic [RANGE_W-1:0] range_high;
  } in_item_t;

  typedef struct packed {
    logic              is_flat;
    err_t              error_code;
    logic [MINC_W-1:0] min_count;
    logic [VBIN_W-1:0] visited_bins;
    logic [SUMO_W-1:0] count_sum;
  } out_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0] active_bins;
    logic [RANGE_W-1:0] min_range;
    logic [CRIT_W-1:0]  flat_criterion;
  } cfg_t;

  typedef struct packed {
    logic                  visited;
    logic [COUNT_BITS-1:0] count;
  } ram_word_t;

endpackage

### hdl/fhm_ram.sv
module fhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/fhm_cfg.sv
module fhm_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhm_pkg::PADDR_W-1:0] paddr,
  input  logic [fhm_pkg::PDATA_W-1:0] pwdata,
  output logic [fhm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output fhm_pkg::cfg_t               cfg
);

  import fhm_pkg::*;

  cfg_t                 cfg_r, cfg_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_ACTIVE_BINS: cfg_nxt.active_bins    = pwdata[RANGE_W-1:0];
        REG_MIN_RANGE:   cfg_nxt.min_range      = pwdata[RANGE_W-1:0];
        REG_FLAT_CRIT:   cfg_nxt.flat_criterion = pwdata[CRIT_W-1:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_bins    <= ACTIVE_BINS_RST;
      cfg_r.min_range      <= MIN_RANGE_RST;
      cfg_r.flat_criterion <= FLAT_CRIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE_BINS: prdata = PDATA_W'(cfg_r.active_bins);
      REG_MIN_RANGE:   prdata = PDATA_W'(cfg_r.min_range);
      REG_FLAT_CRIT:   prdata = PDATA_W'(cfg_r.flat_criterion);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;

endmodule

### hdl/fhm_engine.sv
`include "flat_histogram_monitor_defines.svh"

module fhm_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  fhm_pkg::cfg_t       cfg,
  input  logic                in_valid,
  output logic                in_stall,
  input  fhm_pkg::in_item_t   in_item,
  output logic                res_valid,
  input  logic                res_ready,
  output fhm_pkg::out_item_t  res_item
);

  import fhm_pkg::*;

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0]     clr_idx_r, clr_idx_nxt;
  logic                  clr_resp_r, clr_resp_nxt;
  logic [ADDR_W-1:0]     vbin_r, vbin_nxt;
  logic [RANGE_W-1:0]    idx_r, idx_nxt;
  logic [RANGE_W-1:0]    left_r, left_nxt;
  logic                  pend_r, pend_nxt;
  logic [COUNT_BITS-1:0] mn_r, mn_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [PROD_W-1:0]     prod_a_r, prod_a_nxt;
  logic [PROD_W-1:0]     mul_r, mul_nxt;
  out_item_t             res_r, res_nxt;

  logic [RANGE_W-1:0] nb;
  logic [RANGE_W-1:0] qlen;
  logic               bin_bad, q_bad, q_short;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  ram_word_t         rd_word, visit_word;

  logic [SUM_W-1:0]  mul_x;
  logic [MULY_W-1:0] mul_y;
  logic [PROD_W-1:0] mul_p;
  logic              flat_cmp;

  // decode of the item at the input
  assign nb      = (int'(cfg.active_bins) < NUM_BINS) ? cfg.active_bins : RANGE_W'(NUM_BINS);
  assign bin_bad = RANGE_W'(in_item.bin_index) >= nb;
  assign q_bad   = (in_item.range_high < in_item.range_low) || (in_item.range_high > nb);
  assign qlen    = in_item.range_high - in_item.range_low;
  assign q_short = qlen < cfg.min_range;

  assign rd_word = ram_word_t'(ram_rdata);

  always_comb begin
    visit_word.visited = 1'b1;
    if (!rd_word.visited) begin
      visit_word.count = COUNT_BITS'(1);
    end else if (rd_word.count == COUNT_MAX) begin
      visit_word.count = rd_word.count;
    end else begin
      visit_word.count = rd_word.count + COUNT_BITS'(1);
    end
  end

  // shared multiplier: min times count, then criterion times sum
  assign mul_x = (state_r == S_MUL2) ? sum_r : SUM_W'(mn_r);
  assign mul_y = (state_r == S_MUL2) ? MULY_W'(cfg.flat_criterion) : MULY_W'(n_r);
  assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

  assign flat_cmp = {prod_a_r, {FLAT_SHIFT{1'b0}}} >= {{FLAT_SHIFT{1'b0}}, mul_r};

  fhm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = clr_resp_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_item.operation)
            OP_VISIT: state_nxt = bin_bad ? S_RESP : S_VWR;
            OP_QUERY: state_nxt = (q_bad || q_short) ? S_RESP : S_QRD;
            OP_CLEAR: state_nxt = S_CLR;
            OP_NOP:   state_nxt = S_RESP;
          endcase
        end
      end
      S_VWR: state_nxt = S_RESP;
      S_QRD: begin
        if (left_r == '0) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_CMP;
      S_CMP:  state_nxt = S_RESP;
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    in_stall  = state_r != S_IDLE;
    res_valid = state_r == S_RESP;
    res_item  = res_r;
    ram_we    = (state_r == S_CLR) || (state_r == S_VWR);
    ram_waddr = (state_r == S_CLR) ? clr_idx_r : vbin_r;
    ram_wdata = (state_r == S_CLR) ? '0 : WORD_W'(visit_word);
    if (state_r == S_QRD) begin
      ram_raddr = idx_r[ADDR_W-1:0];
    end else if (in_item.operation == OP_QUERY) begin
      ram_raddr = in_item.range_low[ADDR_W-1:0];
    end else begin
      ram_raddr = ADDR_W'(in_item.bin_index);
    end
  end

  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_resp_nxt = clr_resp_r;
    vbin_nxt     = vbin_r;
    idx_nxt      = idx_r;
    left_nxt     = left_r;
    pend_nxt     = pend_r;
    mn_nxt       = mn_r;
    sum_nxt      = sum_r;
    n_nxt        = n_r;
    prod_a_nxt   = prod_a_r;
    mul_nxt      = mul_r;
    res_nxt      = res_r;
    unique case (state_r)
      S_CLR: begin
        clr_idx_nxt = clr_idx_r + ADDR_W'(1);
        if (clr_idx_r == CLR_LAST) begin
          clr_resp_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          vbin_nxt = ADDR_W'(in_item.bin_index);
          mn_nxt   = COUNT_MAX;
          sum_nxt  = '0;
          n_nxt    = '0;
          idx_nxt  = in_item.range_low + RANGE_W'(1);
          pend_nxt = qlen != '0;
          left_nxt = (qlen == '0) ? '0 : qlen - RANGE_W'(1);
          res_nxt  = '0;
          res_nxt.error_code = ERR_OK;
          unique case (in_item.operation)
            OP_VISIT: begin
              if (bin_bad) begin
                res_nxt.error_code = ERR_BIN;
              end
            end
            OP_QUERY: begin
              if (q_bad) begin
                res_nxt.error_code = ERR_RANGE;
              end else if (q_short) begin
                res_nxt.error_code = ERR_SHORT;
              end
            end
            OP_CLEAR: clr_resp_nxt = 1'b1;
            OP_NOP:   res_nxt.error_code = ERR_OK;
          endcase
        end
      end
      S_VWR: begin
        vbin_nxt = vbin_r;
      end
      S_QRD: begin
        if (left_r != '0) begin
          idx_nxt  = idx_r + RANGE_W'(1);
          left_nxt = left_r - RANGE_W'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_word.visited) begin
          if (rd_word.count < mn_r) begin
            mn_nxt = rd_word.count;
          end
          sum_nxt = sum_r + SUM_W'(rd_word.count);
          n_nxt   = n_r + CNT_W'(1);
        end
      end
      S_MUL1: begin
        mul_nxt = mul_p;
      end
      S_MUL2: begin
        prod_a_nxt = mul_r;
        mul_nxt    = mul_p;
      end
      S_CMP: begin
        res_nxt.error_code   = ERR_OK;
        res_nxt.visited_bins = VBIN_W'(n_r);
        res_nxt.count_sum    = SUMO_W'(sum_r);
        if (n_r == '0) begin
          res_nxt.is_flat   = cfg.flat_criterion == '0;
          res_nxt.min_count = '1;
        end else begin
          res_nxt.is_flat   = flat_cmp;
          res_nxt.min_count = MINC_W'(mn_r);
        end
      end
      S_RESP: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      clr_idx_r  <= '0;
      clr_resp_r <= 1'b0;
      pend_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      clr_resp_r <= clr_resp_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    vbin_r   <= vbin_nxt;
    idx_r    <= idx_nxt;
    left_r   <= left_nxt;
    mn_r     <= mn_nxt;
    sum_r    <= sum_nxt;
    n_r      <= n_nxt;
    prod_a_r <= prod_a_nxt;
    mul_r    <= mul_nxt;
    res_r    <= res_nxt;
  end

  `FHM_ASSERT_NEXT(a_clr_done, clk, rst_n, state_r == S_CLR && clr_idx_r == CLR_LAST, state_r != S_CLR)
  `FHM_ASSERT_NEXT(a_scan_count, clk, rst_n, state_r == S_QRD && pend_r && rd_word.visited, n_r == $past(n_r) + CNT_W'(1))
  `FHM_ASSERT_IMPL(a_min_le_sum, clk, rst_n, state_r == S_MUL1 && n_r != '0, SUM_W'(mn_r) <= sum_r)

endmodule

### hdl/flat_histogram_monitor.sv
// Visit histogram for flat-histogram sampling. Operation visit marks a bin and
// bumps its saturating count; query scans [range_low, range_high) and returns
// min, sum and number of visited bins plus the verdict
// min * visited * 256 >= flat_criterion * sum; clear drops all marks. Counts
// and marks live in one single-port-write, registered-read RAM. A visit reads
// the bin and writes it back; a query reads its bins one by one, multiplies
// twice and compares; a clear writes every bin; a rejected or unused item
// goes straight to the result. After reset a clearing pass over all NUM_BINS
// (1024) bins runs with in_stall high; register writes are taken meanwhile.
// The result register lets the next item be taken while a result still waits
// on out_stall; a further result holds the engine until that register frees.
`include "flat_histogram_monitor_defines.svh"

module flat_histogram_monitor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fhm_pkg::in_item_t           in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fhm_pkg::out_item_t          out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fhm_pkg::PADDR_W-1:0] paddr,
  input  logic [fhm_pkg::PDATA_W-1:0] pwdata,
  output logic [fhm_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  import fhm_pkg::*;

  cfg_t      cfg;
  logic      res_valid, res_ready;
  out_item_t res_item;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  fhm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fhm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_item_nxt  = res_item;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `FHM_ASSERT_NEXT(a_res_load, clk, rst_n, res_valid && res_ready, out_valid_r && out_item_r == $past(res_item))

endmodule
